FILE: hdl/tlbf_pkg.sv
`timescale 1ns / 1ps

package tlbf_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_W   = 5;

  localparam logic [CFG_W-1:0] TLB_SIZE_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  // One stored translation
  typedef struct packed {
    logic [KEY_W-1:0]   pid;
    logic [KEY_W-1:0]   page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic flush;
    logic remove;
  } cell_ctrl_t;

endpackage

FILE: hdl/tlbf_if.sv
`timescale 1ns / 1ps

interface tlbf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] pid;
  logic [15:0] page;
  logic [15:0] frame;

  modport source (output valid, command, pid, page, frame, input ready);
  modport sink   (input valid, command, pid, page, frame, output ready);
endinterface

interface tlbf_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] frame_out;
  logic [31:0] lookup_count;
  logic [31:0] hit_count;

  modport source (output valid, found, frame_out, lookup_count, hit_count, input ready);
  modport sink   (input valid, found, frame_out, lookup_count, hit_count, output ready);
endinterface

interface tlbf_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/tlbf_cell.sv
`timescale 1ns / 1ps

module tlbf_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tlbf_pkg::cell_ctrl_t ctrl,
  input  tlbf_pkg::entry_t   req_entry,
  input  logic               wr_en,
  input  logic               shift_in,
  input  logic               nbr_valid,
  input  tlbf_pkg::entry_t   nbr_entry,
  output logic               shift_out,
  output logic               valid,
  output tlbf_pkg::entry_t   ent,
  output logic               hit
);
  import tlbf_pkg::*;

  // Compare the request key against this entry
  assign hit = valid && (ent.pid == req_entry.pid) && (ent.page == req_entry.page);

  // Move up from the neighbor at or after the dropped position
  assign shift_out = shift_in | (ctrl.remove & hit);

  // Hold the valid bit: clear on flush, set on write, else take it from the neighbor on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      if (ctrl.flush) begin
        valid <= 1'b0;
      end else if (wr_en) begin
        valid <= 1'b1;
      end else if (shift_out) begin
        valid <= nbr_valid;
      end
    end
  end

  // Payload: new entry on write, neighbor's entry on a shift
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_en) begin
        ent <= req_entry;
      end else if (shift_out) begin
        ent <= nbr_entry;
      end
    end
  end

endmodule

FILE: hdl/tlb_fifo_lookup_insert.sv
`timescale 1ns / 1ps

// Fully associative TLB with first-in first-out replacement.
// Channels: req (sink) carries command, pid, page and frame; rsp (source)
// returns found, frame_out, lookup_count and hit_count, one per request;
// cfg (sink) writes tlb_size, the number of entries used before eviction.
// cfg is always ready and should be written only while the block is idle.
// Each request is handled in the cycle it is accepted: all cells compare
// the key in parallel and a shift flag ripples down the row of cells, so
// an eviction or removal moves every later entry up by one at that edge.
// The response is registered and appears in the cycle after the request is accepted;
// throughput is one request per cycle while rsp is ready, limited by the single output register.
// When rsp stalls, the response holds in the output register and req.ready
// drops until it is taken.
// Reset (rst, synchronous) empties the table, clears both counters, sets
// tlb_size to 16 and drops the response; no clearing pass is needed.
module tlb_fifo_lookup_insert #(
  parameter int unsigned TLB_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  tlbf_req_if.sink   req,
  tlbf_rsp_if.source rsp,
  tlbf_cfg_if.sink   cfg
);
  import tlbf_pkg::*;

  localparam int unsigned CW = $clog2(TLB_DEPTH + 1);
  localparam int unsigned EW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0] tlb_size;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CNT_W-1:0] accesses;
  logic [CNT_W-1:0] accesses_next;
  logic [CNT_W-1:0] hits;
  logic [CNT_W-1:0] hits_next;

  logic             req_acc;
  cell_ctrl_t       ctrl;
  entry_t           req_entry;
  logic             is_lookup;
  logic             is_insert;
  logic             is_remove;
  logic             any_hit;
  logic             full;
  logic             evict;
  logic             ins_write;
  logic [CW-1:0]    wr_pos;
  logic [EW-1:0]    size_ext;
  logic [EW-1:0]    eff_size;
  logic [FRAME_W-1:0] hit_frame;

  logic               valid_vec [TLB_DEPTH];
  entry_t             ent_vec   [TLB_DEPTH];
  logic [TLB_DEPTH-1:0] hit_vec;
  logic [TLB_DEPTH-1:0] wr_vec;
  logic               shift_chain [TLB_DEPTH+1];
  logic               nbr_valid [TLB_DEPTH];
  entry_t             nbr_entry [TLB_DEPTH];

  // Accept a request whenever the output register is free or draining
  assign req.ready = !rsp.valid || rsp.ready;
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign req_entry = '{pid: req.pid, page: req.page, frame: req.frame};
  assign is_lookup = (req.command == CMD_LOOKUP);
  assign is_insert = (req.command == CMD_INSERT);
  assign is_remove = (req.command == CMD_REMOVE);
  assign ctrl.flush  = (req.command == CMD_FLUSH);
  assign ctrl.remove = is_remove;

  // Clamp the configured size into one..TLB_DEPTH
  assign size_ext = EW'(tlb_size);
  always_comb begin
    if (size_ext == '0) begin
      eff_size = EW'(1);
    end else if (size_ext > EW'(TLB_DEPTH)) begin
      eff_size = EW'(TLB_DEPTH);
    end else begin
      eff_size = size_ext;
    end
  end

  assign any_hit   = |hit_vec;
  assign full      = (EW'(count) >= eff_size);
  assign ins_write = is_insert && !any_hit;
  assign evict     = ins_write && full;
  assign wr_pos    = evict ? (count - CW'(1)) : count;

  // Eviction starts the shift at the oldest cell
  assign shift_chain[0] = evict;

  for (genvar i = 0; i < TLB_DEPTH; i++) begin : g_cell
    assign wr_vec[i] = ins_write && (wr_pos == CW'(i));

    if (i == TLB_DEPTH - 1) begin : g_last
      assign nbr_valid[i] = 1'b0;
      assign nbr_entry[i] = '0;
    end else begin : g_mid
      assign nbr_valid[i] = valid_vec[i+1];
      assign nbr_entry[i] = ent_vec[i+1];
    end

    tlbf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (req_acc),
      .ctrl      (ctrl),
      .req_entry (req_entry),
      .wr_en     (wr_vec[i]),
      .shift_in  (shift_chain[i]),
      .nbr_valid (nbr_valid[i]),
      .nbr_entry (nbr_entry[i]),
      .shift_out (shift_chain[i+1]),
      .valid     (valid_vec[i]),
      .ent       (ent_vec[i]),
      .hit       (hit_vec[i])
    );
  end

  // Select the matching frame; keys are unique so an OR suffices
  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (hit_vec[i]) begin
        hit_frame = hit_frame | ent_vec[i].frame;
      end
    end
  end

  // Update fill count and statistics
  always_comb begin
    count_next    = count;
    accesses_next = accesses;
    hits_next     = hits;
    if (ctrl.flush) begin
      count_next = '0;
    end else if (ins_write && !evict) begin
      count_next = count + CW'(1);
    end else if (is_remove && any_hit) begin
      count_next = count - CW'(1);
    end
    if (is_lookup) begin
      accesses_next = accesses + CNT_W'(1);
      if (any_hit) begin
        hits_next = hits + CNT_W'(1);
      end
    end
  end

  // Hold state, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      accesses <= '0;
      hits     <= '0;
      tlb_size <= TLB_SIZE_RESET;
    end else begin
      if (req_acc) begin
        count    <= count_next;
        accesses <= accesses_next;
        hits     <= hits_next;
      end
      if (cfg.valid && cfg.ready) begin
        tlb_size <= cfg.data;
      end
    end
  end

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req_acc) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      rsp.found        <= is_lookup && any_hit;
      rsp.frame_out    <= is_lookup ? hit_frame : '0;
      rsp.lookup_count <= accesses_next;
      rsp.hit_count    <= hits_next;
    end
  end

`ifndef ASSERT_OFF
  logic packed_ok;
  always_comb begin
    packed_ok = 1'b1;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (valid_vec[i] != (CW'(i) < count)) begin
        packed_ok = 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TLB_DEPTH))
    else $error("fill count above table depth");

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("key matched more than one entry");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    packed_ok)
    else $error("valid entries not packed below the fill count");

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (req_acc && ctrl.flush) |=> (count == '0))
    else $error("table not empty after flush");

  a_hits_stable: assert property (@(posedge clk) disable iff (rst)
    (req_acc && !is_lookup) |=> $stable(hits))
    else $error("hit counter moved on a non-lookup request");
`endif

endmodule

FILE: test/tb_tlb_fifo_lookup_insert.sv
`timescale 1ns / 1ps

module tb_tlb_fifo_lookup_insert;
  import tlbf_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_REQS = 95;

  typedef enum logic [1:0] {
    ACT_REQ,
    ACT_CFG,
    ACT_DRAIN
  } act_kind_t;

  typedef struct {
    act_kind_t   kind;
    cmd_t        cmd;
    logic [15:0] pid;
    logic [15:0] page;
    logic [15:0] frame;
    logic [4:0]  size;
    int unsigned gap;
  } stim_t;

  typedef struct packed {
    logic        found;
    logic [15:0] frame_out;
    logic [31:0] lookup_count;
    logic [31:0] hit_count;
  } tlb_rsp_t;

  logic clk;
  logic rst;

  tlbf_req_if req_bus ();
  tlbf_rsp_if rsp_bus ();
  tlbf_cfg_if cfg_bus ();

  tlb_fifo_lookup_insert #(
    .TLB_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .cfg(cfg_bus)
  );

  // Shadow copy of the translation table
  entry_t      slots [DEPTH];
  int unsigned fill;
  logic [31:0] lookups;
  logic [31:0] hits;
  logic [4:0]  tlb_size;

  stim_t       stim_q [$];
  tlb_rsp_t    rsp_q [$];
  int unsigned n_accepted;
  int unsigned n_retired;
  int unsigned errors;
  bit          stim_done;
  bit          req_hold;
  bit          cfg_hold;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned rsp_calm_left;
  int unsigned req_calm_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold reset with every input at a known value
  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.command = CMD_LOOKUP;
    req_bus.pid = '0;
    req_bus.page = '0;
    req_bus.frame = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    rsp_bus.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned eff_size();
    if (tlb_size == 0) return 1;
    if (tlb_size > DEPTH) return DEPTH;
    return tlb_size;
  endfunction

  function automatic int find_slot(logic [15:0] pid, logic [15:0] page);
    for (int i = 0; i < int'(fill); i++) begin
      if (slots[i].pid == pid && slots[i].page == page) return i;
    end
    return -1;
  endfunction

  // Drop one entry and close the gap behind it
  function automatic void evict(int pos);
    for (int i = pos; i + 1 < int'(fill); i++) slots[i] = slots[i+1];
    fill--;
  endfunction

  // Apply one request to the shadow table and return its response
  function automatic tlb_rsp_t translate(cmd_t cmd, logic [15:0] pid, logic [15:0] page,
                                         logic [15:0] frame);
    tlb_rsp_t r;
    int pos;
    r = '0;
    pos = find_slot(pid, page);
    case (cmd)
      CMD_LOOKUP: begin
        lookups++;
        if (pos >= 0) begin
          hits++;
          r.found = 1'b1;
          r.frame_out = slots[pos].frame;
        end
      end
      CMD_INSERT: begin
        // keep a stale frame when the key is already there
        if (pos < 0) begin
          if (fill >= eff_size() || fill >= DEPTH) evict(0);
          if (fill < DEPTH) begin
            slots[fill] = '{pid: pid, page: page, frame: frame};
            fill++;
          end
        end
      end
      CMD_REMOVE: begin
        if (pos >= 0) evict(pos);
      end
      default: begin
        fill = 0;
      end
    endcase
    r.lookup_count = lookups;
    r.hit_count = hits;
    return r;
  endfunction

  function automatic void queue_request(cmd_t cmd, logic [15:0] pid, logic [15:0] page,
                                        logic [15:0] frame);
    stim_t s;
    s.kind = ACT_REQ;
    s.cmd = cmd;
    s.pid = pid;
    s.page = page;
    s.frame = frame;
    s.size = '0;
    if (req_calm_left != 0) begin
      req_calm_left--;
      s.gap = 0;
    end else begin
      s.gap = pick_gap();
      if ($urandom_range(0, 39) == 0) req_calm_left = $urandom_range(20, 60);
    end
    stim_q.push_back(s);
  endfunction

  function automatic void queue_marker(act_kind_t kind, logic [4:0] size);
    stim_t s;
    s.kind = kind;
    s.cmd = CMD_LOOKUP;
    s.pid = '0;
    s.page = '0;
    s.frame = '0;
    s.size = size;
    s.gap = 0;
    stim_q.push_back(s);
  endfunction

  // Random request, keys mostly from a small pool so that hits and evictions occur
  function automatic void queue_random();
    cmd_t cmd;
    logic [15:0] pid;
    logic [15:0] page;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) cmd = CMD_LOOKUP;
    else if (r < 82) cmd = CMD_INSERT;
    else if (r < 98) cmd = CMD_REMOVE;
    else cmd = CMD_FLUSH;
    if ($urandom_range(0, 9) == 0) begin
      pid = 16'($urandom());
      page = 16'($urandom());
    end else begin
      pid = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 2)) : 16'hFFFF;
      page = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 5)) : 16'hFFFF;
    end
    queue_request(cmd, pid, page, 16'($urandom()));
  endfunction

  // Build the whole request list up front
  initial begin : build_stim
    logic [4:0] size_plan [PHASES];
    size_plan = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd17, 5'd8, 5'd16, 5'd2, 5'd0, 5'd5, 5'd16};
    size_plan[9] = 5'($urandom_range(0, 31));
    req_calm_left = 0;

    // directed: extremes, stale insert, absent remove, flush
    queue_request(CMD_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF);
    queue_request(CMD_INSERT, 16'h0000, 16'h0000, 16'hFFFF);
    queue_request(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000);
    queue_request(CMD_INSERT, 16'h0000, 16'h0000, 16'h1234);
    queue_request(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000);
    queue_request(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_request(CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_request(CMD_INSERT, 16'hFFFF, 16'h0000, 16'hA5A5);
    queue_request(CMD_INSERT, 16'h0000, 16'hFFFF, 16'h5A5A);
    queue_request(CMD_LOOKUP, 16'hFFFF, 16'h0000, 16'h0000);
    queue_request(CMD_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000);
    queue_request(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_request(CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_request(CMD_REMOVE, 16'h0001, 16'h0001, 16'hFFFF);
    queue_request(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000);
    queue_request(CMD_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_request(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000);
    queue_request(CMD_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000);

    // random phases, each under its own table size
    for (int p = 0; p < int'(PHASES); p++) begin
      queue_marker(ACT_CFG, size_plan[p]);
      for (int i = 0; i < int'(PHASE_REQS); i++) begin
        if ($urandom_range(0, 99) == 0) queue_marker(ACT_DRAIN, '0);
        queue_random();
      end
    end
  end

  // Driver: present queued requests and size writes
  always @(posedge clk) begin : drive
    stim_t nxt;
    if (rst) begin
      req_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
      req_hold = 1'b0;
      cfg_hold = 1'b0;
      gap_left = 0;
      n_accepted = 0;
      stim_done = 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        n_accepted++;
        req_hold = 1'b0;
      end
      if (cfg_bus.valid && cfg_bus.ready) cfg_hold = 1'b0;
      if (!req_hold && !cfg_hold) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          nxt = stim_q[0];
          case (nxt.kind)
            ACT_REQ: begin
              req_bus.command <= nxt.cmd;
              req_bus.pid <= nxt.pid;
              req_bus.page <= nxt.page;
              req_bus.frame <= nxt.frame;
              req_hold = 1'b1;
              gap_left = nxt.gap;
              stim_q.delete(0);
            end
            ACT_CFG: begin
              // write the size only once every response is back
              if (n_accepted == n_retired) begin
                cfg_bus.data <= nxt.size;
                cfg_hold = 1'b1;
                stim_q.delete(0);
              end
            end
            default: begin
              if (n_accepted == n_retired) stim_q.delete(0);
            end
          endcase
        end
      end
      stim_done = !req_hold && !cfg_hold && (stim_q.size() == 0);
      req_bus.valid <= req_hold;
      cfg_bus.valid <= cfg_hold;
    end
  end

  // Monitor: predict on each accepted request, check each accepted response
  always @(posedge clk) begin : observe
    tlb_rsp_t got;
    tlb_rsp_t want;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      fill = 0;
      lookups = '0;
      hits = '0;
      tlb_size = TLB_SIZE_RESET;
      n_retired = 0;
      errors = 0;
      stall_left = 0;
      rsp_calm_left = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        rsp_q.push_back(translate(cmd_t'(req_bus.command), req_bus.pid, req_bus.page,
                                  req_bus.frame));
      end
      if (cfg_bus.valid && cfg_bus.ready) tlb_size = cfg_bus.data;

      if (rsp_bus.valid && rsp_bus.ready) begin
        got = '{found: rsp_bus.found, frame_out: rsp_bus.frame_out,
                lookup_count: rsp_bus.lookup_count, hit_count: rsp_bus.hit_count};
        if (rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          want = rsp_q.pop_front();
          n_retired++;
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            errors++;
          end
          if (got.frame_out !== want.frame_out) begin
            $error("frame_out: expected %0h, actual %0h", want.frame_out, got.frame_out);
            errors++;
          end
          if (got.lookup_count !== want.lookup_count) begin
            $error("lookup_count: expected %0d, actual %0d",
                   want.lookup_count, got.lookup_count);
            errors++;
          end
          if (got.hit_count !== want.hit_count) begin
            $error("hit_count: expected %0d, actual %0d", want.hit_count, got.hit_count);
            errors++;
          end
        end
        // stall after this response, except during calm stretches
        if (rsp_calm_left != 0) begin
          rsp_calm_left--;
        end else begin
          stall_left = pick_gap();
          if ($urandom_range(0, 49) == 0) rsp_calm_left = $urandom_range(30, 80);
        end
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rsp_bus.ready <= (stall_left == 0);
    end
  end

  // Wait for the last response, then report
  initial begin : finish_run
    @(negedge rst);
    @(posedge clk);
    while (!(stim_done && n_accepted == n_retired)) @(posedge clk);
    repeat (20) @(posedge clk);
    if (rsp_q.size() != 0) begin
      $error("%0d responses never arrived", rsp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hang
  initial begin : watchdog
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
